### design/tsrg_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tsrg_pkg
// Shared types and constants of the trend, season and residual gradient
// engine: transaction payloads, command codes, register indexes, state codes
// and the CORDIC arctangent table.
// ============================================================================
package tsrg_pkg;

   // command codes on req_data.cmd
   localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
   localparam logic [1:0] CMD_LOAD_CP   = 2'd1;
   localparam logic [1:0] CMD_SAMPLE    = 2'd2;
   localparam logic [1:0] CMD_FINISH    = 2'd3;

   // configuration register indexes
   localparam int CSR_IW = 3;
   localparam logic [CSR_IW-1:0] CSR_INV_VAR_OBS       = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_INV_VAR_RATE      = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_INV_VAR_OFFSET    = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_INV_VAR_SEASON    = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_INV_LAPLACE_SCALE = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_PHASE_RATE        = 3'd5;

   localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   // CORDIC
   localparam int CORDIC_STEPS = 24;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] CORDIC_ATAN [CORDIC_STEPS] = '{
      34'sd536870912, 34'sd316933461, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81
   };

   typedef struct packed {
      logic [1:0]         cmd;
      logic [5:0]         slot;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } tsrg_req_type;

   typedef struct packed {
      logic [5:0]         grad_index;
      logic signed [63:0] grad_value;
      logic               last;
   } tsrg_rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD_COEF,
      OP_LOAD_CP,
      OP_SAMPLE,
      OP_FINISH
   } op_kind_type;

   typedef struct packed {
      op_kind_type        kind;
      logic               slot_ok;
      logic [5:0]         slot;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } tsrg_op_type;

   typedef struct packed {
      logic [31:0] inv_var_obs;
      logic [31:0] inv_var_rate;
      logic [31:0] inv_var_offset;
      logic [31:0] inv_var_season;
      logic [31:0] inv_laplace_scale;
      logic [31:0] phase_rate;
   } tsrg_cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BASE,
      ST_TREND_K,
      ST_TREND_M,
      ST_CP_RD,
      ST_CP_MUL,
      ST_CP_ADD,
      ST_H_PHASE,
      ST_H_CORDIC,
      ST_H_COS,
      ST_H_SIN,
      ST_H_ADD,
      ST_NR,
      ST_A_PRE,
      ST_A_ISS,
      ST_A_WR,
      ST_F_RD,
      ST_F_HI,
      ST_F_LO,
      ST_F_PR,
      ST_F_OUT
   } back_state_type;

endpackage

### design/tsrg_front.sv
`timescale 1ns / 1ps
// ============================================================================
// tsrg_front
// Accepts request transactions, decodes the command and checks the slot
// against its store, and holds decoded operations in a short queue.
// ============================================================================
module tsrg_front import tsrg_pkg::*; #(
   parameter int NUM_CHANGEPOINTS = 25,
   parameter int NUM_COEFS        = 47
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  tsrg_req_type req_data,
   output logic         op_valid,
   input  logic         op_pop,
   output tsrg_op_type  op_data
);

   tsrg_op_type           queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   head_ff, head_in;
   logic [QUEUE_AW-1:0]   tail_ff, tail_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   tsrg_op_type           op_in;
   logic                  push_ok;
   logic                  pop_ok;

   always_comb begin
      op_in.slot      = req_data.slot;
      op_in.operand_a = req_data.operand_a;
      op_in.operand_b = req_data.operand_b;
      case (req_data.cmd)
         CMD_LOAD_COEF: begin
            op_in.kind    = OP_LOAD_COEF;
            op_in.slot_ok = 32'(req_data.slot) < 32'(NUM_COEFS);
         end
         CMD_LOAD_CP: begin
            op_in.kind    = OP_LOAD_CP;
            op_in.slot_ok = 32'(req_data.slot) < 32'(NUM_CHANGEPOINTS);
         end
         CMD_SAMPLE: begin
            op_in.kind    = OP_SAMPLE;
            op_in.slot_ok = 1'b1;
         end
         default: begin
            op_in.kind    = OP_FINISH;
            op_in.slot_ok = 1'b1;
         end
      endcase
   end

   assign req_full = count_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign op_valid = count_ff != '0;
   assign op_data  = queue_ff[head_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = op_pop && op_valid;

   always_comb begin
      head_in  = pop_ok  ? head_ff + 1'b1 : head_ff;
      tail_in  = push_ok ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[tail_ff] <= op_in;
      end
   end

endmodule

### design/tsrg_back.sv
`timescale 1ns / 1ps
// ============================================================================
// tsrg_back
// Executes queued operations: coefficient and changepoint stores, the trend
// and seasonality model with an iterative CORDIC, gradient accumulation and
// the finish pass; all products use one shared registered multiplier.
// ============================================================================
module tsrg_back import tsrg_pkg::*; #(
   parameter int NUM_CHANGEPOINTS = 25,
   parameter int NUM_HARMONICS    = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  tsrg_cfg_type cfg,
   input  logic         op_valid,
   output logic         op_pop,
   input  tsrg_op_type  op_data,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output tsrg_rsp_type rsp_data
);

   localparam int NCP = NUM_CHANGEPOINTS;
   localparam int NH  = NUM_HARMONICS;
   localparam int NC  = 2 + NCP + 2 * NH;
   localparam int AW  = $clog2(NC);
   localparam int CW  = $clog2(NC + 1);
   localparam int CPW = (NCP > 1) ? $clog2(NCP) : 1;
   localparam int HW  = (NH > 1) ? $clog2(NH) : 1;
   localparam int HCW = $clog2(NH + 1);
   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   // stores
   logic signed [31:0] coef_mem [NC];
   logic signed [31:0] cp_mem [NCP];
   logic signed [63:0] acc_mem [NC];
   logic [NC-1:0]      acc_vld_ff;
   logic signed [31:0] cos_ff [NH];
   logic signed [31:0] sin_ff [NH];

   back_state_type     state_ff, state_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [HCW-1:0]     h_ff, h_in;
   logic [4:0]         step_ff, step_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [63:0] sum_ff, sum_in;
   logic [47:0]        base_ff, base_in;
   logic [47:0]        ph_ff, ph_in;
   logic signed [33:0] cx_ff, cx_in;
   logic signed [33:0] cy_ff, cy_in;
   logic signed [33:0] cz_ff, cz_in;
   logic               flip_ff, flip_in;
   logic               act_ff, act_in;
   logic signed [31:0] nr_ff, nr_in;
   logic [31:0]        mag_lo_ff, mag_lo_in;
   logic [63:0]        fph_ff, fph_in;
   logic signed [63:0] v_ff, v_in;
   logic               aneg_ff, aneg_in;
   logic               cneg_ff, cneg_in;
   logic               czero_ff, czero_in;
   logic [31:0]        cmag_ff, cmag_in;
   tsrg_rsp_type       out_ff, out_in;
   logic               out_vld_ff;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_full;
   logic [63:0]        mul_p_ff;
   logic signed [63:0] p_s;

   logic [AW-1:0]      coef_addr;
   logic signed [31:0] coef_q_ff;
   logic [CPW-1:0]     cp_addr;
   logic signed [31:0] cp_q_ff;
   logic signed [63:0] acc_rd_ff;
   logic               acc_rv_ff;
   logic signed [63:0] acc_q;
   logic               acc_we;
   logic signed [63:0] acc_wdata;
   logic               acc_clr;
   logic               coef_we;
   logic               cp_we;
   logic               cs_we;
   logic               out_load;
   logic               out_free;

   // derived datapath values
   logic               r_rate, r_off, r_cp, r_cos;
   logic [CW-1:0]      hj, hs, jm2;
   logic signed [33:0] c_dx, c_dy, c_at;
   logic signed [33:0] cv34, sv34;
   logic signed [33:0] d_tc;
   logic               t_gt_c;
   logic [31:0]        u_raw, u_add, u_fold;
   logic signed [63:0] term;
   logic signed [63:0] diff;
   logic [63:0]        f_mag;
   logic [63:0]        f_res;
   logic               f_sat;
   logic signed [63:0] pr_mag, d_mag, prior;
   logic [31:0]        scale;

   assign p_s      = $signed(mul_p_ff);
   assign acc_q    = acc_rv_ff ? acc_rd_ff : '0;
   assign mul_full = mul_a * mul_b;
   assign out_free = !out_vld_ff || rsp_pop;

   assign r_rate = i_ff == '0;
   assign r_off  = i_ff == CW'(1);
   assign r_cp   = !r_rate && !r_off && (i_ff < CW'(2 + NCP));
   assign hj     = i_ff - CW'(2 + NCP);
   assign hs     = hj - CW'(NH);
   assign jm2    = i_ff - CW'(2);
   assign r_cos  = !r_rate && !r_off && !r_cp && (hj < CW'(NH));

   assign c_dx = cy_ff >>> step_ff;
   assign c_dy = cx_ff >>> step_ff;
   assign c_at = CORDIC_ATAN[step_ff];
   assign cv34 = flip_ff ? -cx_ff : cx_ff;
   assign sv34 = flip_ff ? -cy_ff : cy_ff;

   assign d_tc   = {{2{t_ff[31]}}, t_ff} - {{2{cp_q_ff[31]}}, cp_q_ff};
   assign t_gt_c = t_ff > cp_q_ff;

   assign u_raw  = ph_in[47:16];
   assign u_add  = u_raw + 32'h4000_0000;
   assign u_fold = u_add[31] ? (u_raw ^ 32'h8000_0000) : u_raw;

   assign term = (r_rate || r_cp) ? (p_s >>> 8) :
                 r_off            ? $signed({{16{nr_ff[31]}}, nr_ff, 16'h0000}) :
                                    (p_s >>> 14);
   assign diff = sum_ff - {{32{y_ff[31]}}, y_ff};

   assign f_mag = acc_q[63] ? 64'(-acc_q) : acc_q;
   assign f_res = {fph_ff[55:0], 8'h00} + {24'h000000, mul_p_ff[63:24]};
   assign f_sat = |fph_ff[63:55];

   assign pr_mag = {8'h00, mul_p_ff[63:8]};
   assign d_mag  = {16'h0000, cfg.inv_laplace_scale, 16'h0000};
   assign scale  = r_rate ? cfg.inv_var_rate :
                   r_off  ? cfg.inv_var_offset : cfg.inv_var_season;

   always_comb begin
      if (r_cp) begin
         prior = czero_ff ? '0 : (cneg_ff ? -d_mag : d_mag);
      end else begin
         prior = cneg_ff ? -pr_mag : pr_mag;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               case (op_data.kind)
                  OP_SAMPLE: state_in = ST_BASE;
                  OP_FINISH: state_in = ST_F_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_BASE:     state_in = ST_TREND_K;
         ST_TREND_K:  state_in = ST_TREND_M;
         ST_TREND_M:  state_in = ST_CP_RD;
         ST_CP_RD:    state_in = ST_CP_MUL;
         ST_CP_MUL:   state_in = ST_CP_ADD;
         ST_CP_ADD:   state_in = (i_ff == CW'(NCP - 1)) ? ST_H_PHASE : ST_CP_RD;
         ST_H_PHASE:  state_in = ST_H_CORDIC;
         ST_H_CORDIC: state_in = (step_ff == 5'(CORDIC_STEPS - 1)) ? ST_H_COS : ST_H_CORDIC;
         ST_H_COS:    state_in = ST_H_SIN;
         ST_H_SIN:    state_in = ST_H_ADD;
         ST_H_ADD:    state_in = (h_ff == HCW'(NH - 1)) ? ST_NR : ST_H_PHASE;
         ST_NR:       state_in = ST_A_PRE;
         ST_A_PRE:    state_in = ST_A_ISS;
         ST_A_ISS:    state_in = ST_A_WR;
         ST_A_WR:     state_in = (i_ff == CW'(NC - 1)) ? ST_IDLE : ST_A_PRE;
         ST_F_RD:     state_in = ST_F_HI;
         ST_F_HI:     state_in = ST_F_LO;
         ST_F_LO:     state_in = ST_F_PR;
         ST_F_PR:     state_in = ST_F_OUT;
         ST_F_OUT: begin
            if (out_free) begin
               state_in = (i_ff == CW'(NC - 1)) ? ST_IDLE : ST_F_RD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      i_in      = i_ff;
      h_in      = h_ff;
      step_in   = step_ff;
      t_in      = t_ff;
      y_in      = y_ff;
      sum_in    = sum_ff;
      base_in   = base_ff;
      ph_in     = ph_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      flip_in   = flip_ff;
      act_in    = act_ff;
      nr_in     = nr_ff;
      mag_lo_in = mag_lo_ff;
      fph_in    = fph_ff;
      v_in      = v_ff;
      aneg_in   = aneg_ff;
      cneg_in   = cneg_ff;
      czero_in  = czero_ff;
      cmag_in   = cmag_ff;
      out_in    = out_ff;
      mul_a     = '0;
      mul_b     = '0;
      coef_addr = '0;
      cp_addr   = i_ff[CPW-1:0];
      acc_we    = 1'b0;
      acc_wdata = sadd64(acc_q, term);
      acc_clr   = 1'b0;
      coef_we   = 1'b0;
      cp_we     = 1'b0;
      cs_we     = 1'b0;
      out_load  = 1'b0;
      op_pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            op_pop = op_valid;
            i_in   = '0;
            t_in   = op_data.operand_a;
            y_in   = op_data.operand_b;
            if (op_valid && op_data.slot_ok) begin
               coef_we = op_data.kind == OP_LOAD_COEF;
               cp_we   = op_data.kind == OP_LOAD_CP;
            end
         end
         ST_BASE: begin
            mul_a = {2'b00, cfg.phase_rate};
            mul_b = {{2{t_ff[31]}}, t_ff};
         end
         ST_TREND_K: begin
            base_in   = mul_p_ff[47:0];
            mul_a     = {{2{coef_q_ff[31]}}, coef_q_ff};
            mul_b     = {{2{t_ff[31]}}, t_ff};
            coef_addr = AW'(1);
         end
         ST_TREND_M: begin
            sum_in = (p_s >>> 24) + coef_q_ff;
            i_in   = '0;
         end
         ST_CP_RD: begin
            coef_addr = AW'(i_ff + CW'(2));
         end
         ST_CP_MUL: begin
            act_in = t_gt_c;
            mul_a  = {{2{coef_q_ff[31]}}, coef_q_ff};
            mul_b  = d_tc;
         end
         ST_CP_ADD: begin
            if (act_ff) begin
               sum_in = sum_ff + (p_s >>> 24);
            end
            i_in  = i_ff + 1'b1;
            h_in  = '0;
            ph_in = '0;
         end
         ST_H_PHASE: begin
            ph_in   = ph_ff + base_ff;
            flip_in = u_add[31];
            cx_in   = CORDIC_GAIN;
            cy_in   = '0;
            cz_in   = {{2{u_fold[31]}}, u_fold};
            step_in = '0;
         end
         ST_H_CORDIC: begin
            coef_addr = AW'(CW'(h_ff) + CW'(2 + NCP));
            if (!cz_ff[33]) begin
               cx_in = cx_ff - c_dx;
               cy_in = cy_ff + c_dy;
               cz_in = cz_ff - c_at;
            end else begin
               cx_in = cx_ff + c_dx;
               cy_in = cy_ff - c_dy;
               cz_in = cz_ff + c_at;
            end
            step_in = step_ff + 1'b1;
         end
         ST_H_COS: begin
            cs_we     = 1'b1;
            mul_a     = {{2{coef_q_ff[31]}}, coef_q_ff};
            mul_b     = cv34;
            coef_addr = AW'(CW'(h_ff) + CW'(2 + NCP + NH));
         end
         ST_H_SIN: begin
            sum_in = sum_ff + (p_s >>> 30);
            mul_a  = {{2{coef_q_ff[31]}}, coef_q_ff};
            mul_b  = sv34;
         end
         ST_H_ADD: begin
            sum_in = sum_ff + (p_s >>> 30);
            h_in   = h_ff + 1'b1;
         end
         ST_NR: begin
            if (diff > 64'sd2147483647) begin
               nr_in = 32'sh7FFF_FFFF;
            end else if (diff < -64'sd2147483648) begin
               nr_in = 32'sh8000_0000;
            end else begin
               nr_in = diff[31:0];
            end
            i_in = '0;
         end
         ST_A_PRE: begin
            cp_addr = jm2[CPW-1:0];
         end
         ST_A_ISS: begin
            mul_a  = {{2{nr_ff[31]}}, nr_ff};
            act_in = 1'b1;
            if (r_rate) begin
               mul_b = {{2{t_ff[31]}}, t_ff};
            end else if (r_cp) begin
               mul_b  = d_tc;
               act_in = t_gt_c;
            end else if (r_cos) begin
               mul_b = {{2{cos_ff[hj[HW-1:0]][31]}}, cos_ff[hj[HW-1:0]]};
            end else begin
               mul_b = {{2{sin_ff[hs[HW-1:0]][31]}}, sin_ff[hs[HW-1:0]]};
            end
         end
         ST_A_WR: begin
            acc_we = act_ff;
            i_in   = i_ff + 1'b1;
         end
         ST_F_RD: begin
            coef_addr = i_ff[AW-1:0];
         end
         ST_F_HI: begin
            aneg_in   = acc_q[63];
            mag_lo_in = f_mag[31:0];
            cneg_in   = coef_q_ff[31];
            czero_in  = coef_q_ff == '0;
            cmag_in   = coef_q_ff[31] ? 32'(-coef_q_ff) : coef_q_ff;
            mul_a     = {2'b00, f_mag[63:32]};
            mul_b     = {2'b00, cfg.inv_var_obs};
         end
         ST_F_LO: begin
            fph_in = mul_p_ff;
            mul_a  = {2'b00, mag_lo_ff};
            mul_b  = {2'b00, cfg.inv_var_obs};
         end
         ST_F_PR: begin
            if (f_sat) begin
               v_in = aneg_ff ? S64_MIN : S64_MAX;
            end else if (aneg_ff) begin
               v_in = f_res[63] ? S64_MIN : -$signed(f_res);
            end else begin
               v_in = f_res[63] ? S64_MAX : $signed(f_res);
            end
            mul_a = {2'b00, cmag_ff};
            mul_b = {2'b00, scale};
         end
         ST_F_OUT: begin
            mul_a             = {2'b00, cmag_ff};
            mul_b             = {2'b00, scale};
            out_in.grad_index = 6'(i_ff);
            out_in.grad_value = sadd64(v_ff, prior);
            out_in.last       = i_ff == CW'(NC - 1);
            if (out_free) begin
               out_load = 1'b1;
               acc_clr  = 1'b1;
               i_in     = i_ff + 1'b1;
            end
         end
         default: begin
            i_in = i_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         acc_vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (acc_we) begin
            acc_vld_ff[i_ff[AW-1:0]] <= 1'b1;
         end else if (acc_clr) begin
            acc_vld_ff[i_ff[AW-1:0]] <= 1'b0;
         end
         if (out_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      h_ff      <= h_in;
      step_ff   <= step_in;
      t_ff      <= t_in;
      y_ff      <= y_in;
      sum_ff    <= sum_in;
      base_ff   <= base_in;
      ph_ff     <= ph_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      flip_ff   <= flip_in;
      act_ff    <= act_in;
      nr_ff     <= nr_in;
      mag_lo_ff <= mag_lo_in;
      fph_ff    <= fph_in;
      v_ff      <= v_in;
      aneg_ff   <= aneg_in;
      cneg_ff   <= cneg_in;
      czero_ff  <= czero_in;
      cmag_ff   <= cmag_in;
      mul_p_ff  <= mul_full[63:0];
      if (out_load) begin
         out_ff <= out_in;
      end
      if (cs_we) begin
         cos_ff[h_ff[HW-1:0]] <= cv34[31:0];
         sin_ff[h_ff[HW-1:0]] <= sv34[31:0];
      end
   end

   // coefficient store
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[AW'(op_data.slot)] <= op_data.operand_a;
      end
      coef_q_ff <= coef_mem[coef_addr];
   end

   // changepoint store
   always_ff @(posedge clock) begin
      if (cp_we) begin
         cp_mem[CPW'(op_data.slot)] <= op_data.operand_a;
      end
      cp_q_ff <= cp_mem[cp_addr];
   end

   // gradient accumulators
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[i_ff[AW-1:0]] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem[i_ff[AW-1:0]];
      acc_rv_ff <= acc_vld_ff[i_ff[AW-1:0]];
   end

   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

### design/trend_season_residual_gradient.sv
`timescale 1ns / 1ps
// ============================================================================
// trend_season_residual_gradient
// Gradient engine for a piecewise-linear trend plus Fourier seasonality
// model: loads coefficients and changepoints, accumulates residual-weighted
// features per sample and emits scaled gradients with prior terms on finish.
// ============================================================================
//
//   channel | ports                               | transaction
//   --------+-------------------------------------+-------------------------
//   request | req_push, req_full, req_data        | one command
//   result  | rsp_empty, rsp_pop, rsp_data        | one gradient component
//   config  | csr_valid, csr_ready, csr_index,    | one register write
//           | csr_wdata                           |
//
// Loads write their store while the back end is idle. A sample runs through the
// single shared multiplier and the one-step-a-cycle CORDIC. Finish steps through
// read, product, prior and output states for each gradient component and stalls
// in the output state while the result register is full. Synchronous reset clears
// control state and the accumulator valid bits; no clearing pass. A four-entry
// queue lets requests arrive while the back end works; a full result register
// stalls the back end only.
module trend_season_residual_gradient import tsrg_pkg::*; #(
   parameter int NUM_CHANGEPOINTS = 25,
   parameter int NUM_HARMONICS    = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  tsrg_req_type      req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tsrg_rsp_type      rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int NUM_COEFS = 2 + NUM_CHANGEPOINTS + 2 * NUM_HARMONICS;

   tsrg_cfg_type cfg_ff, cfg_in;
   logic         op_valid;
   logic         op_pop;
   tsrg_op_type  op_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_INV_VAR_OBS:       cfg_in.inv_var_obs       = csr_wdata;
            CSR_INV_VAR_RATE:      cfg_in.inv_var_rate      = csr_wdata;
            CSR_INV_VAR_OFFSET:    cfg_in.inv_var_offset    = csr_wdata;
            CSR_INV_VAR_SEASON:    cfg_in.inv_var_season    = csr_wdata;
            CSR_INV_LAPLACE_SCALE: cfg_in.inv_laplace_scale = csr_wdata;
            CSR_PHASE_RATE:        cfg_in.phase_rate        = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_var_obs       <= ONE_Q24;
         cfg_ff.inv_var_rate      <= ONE_Q24;
         cfg_ff.inv_var_offset    <= ONE_Q24;
         cfg_ff.inv_var_season    <= ONE_Q24;
         cfg_ff.inv_laplace_scale <= ONE_Q24;
         cfg_ff.phase_rate        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsrg_front #(
      .NUM_CHANGEPOINTS(NUM_CHANGEPOINTS),
      .NUM_COEFS       (NUM_COEFS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .op_valid(op_valid),
      .op_pop  (op_pop),
      .op_data (op_data)
   );

   tsrg_back #(
      .NUM_CHANGEPOINTS(NUM_CHANGEPOINTS),
      .NUM_HARMONICS   (NUM_HARMONICS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .op_valid (op_valid),
      .op_pop   (op_pop),
      .op_data  (op_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Gradient engine testbench
// Loads every coefficient and changepoint, then drives a directed table and
// random phases of loads, samples and finishes. Each phase may start with
// register writes. Gradient components are checked against a local fixed-point
// predictor of trend, seasonality and prior terms, or a value a table row types.
// ============================================================================
module testbench;
   import tsrg_pkg::*;

   localparam int N_CP   = 25;
   localparam int N_HARM = 10;
   localparam int N_COEF = 2 + N_CP + 2 * N_HARM;
   localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SAT_MIN = 64'sh8000_0000_0000_0000;
   localparam int SETTLE_CYCLES = 2500;

   typedef struct {
      tsrg_req_type req;
      bit           typed;
      logic [5:0]   tidx;
      longint       tval;
   } table_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   tsrg_req_type      req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   tsrg_rsp_type      rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [31:0]       csr_wdata = '0;

   logic [31:0] coef_mem [N_COEF];
   logic [31:0] cp_mem [N_CP];
   longint      grad_sum [N_COEF];
   logic [31:0] obs_w, rate_w, offset_w, season_w, laplace_w, phase_w;

   tsrg_rsp_type  grad_expected [$];
   table_row_type stim_table [$];

   int  n_errors = 0;
   int  n_items = 0;
   int  n_samples = 0;
   int  n_finishes = 0;
   int  n_results = 0;
   bit  steady = 1'b0;
   bit  hold_armed = 1'b0;
   bit  typed_on = 1'b0;
   logic [5:0] typed_idx;
   longint     typed_val;

   always #6 clock = ~clock;

   trend_season_residual_gradient i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   task automatic report(input string what, input longint got, input longint want);
      n_errors++;
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   function automatic longint sx(input logic [31:0] w);
      return longint'(signed'(w));
   endfunction

   function automatic longint add_sat(input longint a, input longint b);
      longint r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? SAT_MIN : SAT_MAX;
      return r;
   endfunction

   // magnitude truncated toward zero, saturated
   function automatic longint scale_trunc(input longint a, input logic [31:0] b,
                                          input int sh);
      bit neg;
      longint unsigned mag, hi, lo, res;
      neg = a < 0;
      mag = neg ? 64'd0 - longint'(a) : a;
      hi = (mag >> 32) * {32'd0, b};
      lo = (mag & 64'hFFFF_FFFF) * {32'd0, b};
      if ((hi >> (31 + sh)) != 0) return neg ? SAT_MIN : SAT_MAX;
      res = (hi << (32 - sh)) + (lo >> sh);
      if (neg) return res[63] ? SAT_MIN : -longint'(res);
      return res[63] ? SAT_MAX : longint'(res);
   endfunction

   task automatic rotate(input logic [31:0] ang, output longint cs, output longint sn);
      logic [31:0] u;
      bit flip;
      longint x, y, z, dx, dy;
      u = ang + 32'h4000_0000;
      flip = u[31];
      u = flip ? ang - 32'h8000_0000 : ang;
      z = sx(u);
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(CORDIC_ATAN[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(CORDIC_ATAN[i]);
         end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endtask

   task automatic predict_gradients(input tsrg_req_type r);
      longint t, y, g, s, nr, c, prior, v;
      longint cv [N_HARM];
      longint sv [N_HARM];
      longint unsigned base, ph;
      tsrg_rsp_type o;
      case (r.cmd)
         CMD_LOAD_COEF: if (r.slot < N_COEF) coef_mem[r.slot] = r.operand_a;
         CMD_LOAD_CP:   if (r.slot < N_CP) cp_mem[r.slot] = r.operand_a;
         CMD_SAMPLE: begin
            t = longint'(r.operand_a);
            y = longint'(r.operand_b);
            base = {32'd0, phase_w} * longint'(t);
            g = ((sx(coef_mem[0]) * t) >>> 24) + sx(coef_mem[1]);
            for (int i = 0; i < N_CP; i++) begin
               c = sx(cp_mem[i]);
               if (t > c) g += (sx(coef_mem[2 + i]) * (t - c)) >>> 24;
            end
            s = 0;
            for (int i = 0; i < N_HARM; i++) begin
               ph = base * longint'(i + 1);
               rotate(ph[47:16], cv[i], sv[i]);
               s += (sx(coef_mem[2 + N_CP + i]) * cv[i]) >>> 30;
               s += (sx(coef_mem[2 + N_CP + N_HARM + i]) * sv[i]) >>> 30;
            end
            nr = g + s - y;
            if (nr > 64'sd2147483647) nr = 64'sd2147483647;
            if (nr < -64'sd2147483648) nr = -64'sd2147483648;
            grad_sum[0] = add_sat(grad_sum[0], (nr * t) >>> 8);
            grad_sum[1] = add_sat(grad_sum[1], nr * 65536);
            for (int i = 0; i < N_CP; i++) begin
               c = sx(cp_mem[i]);
               if (t > c) grad_sum[2 + i] = add_sat(grad_sum[2 + i], (nr * (t - c)) >>> 8);
            end
            for (int i = 0; i < N_HARM; i++) begin
               grad_sum[2 + N_CP + i] =
                  add_sat(grad_sum[2 + N_CP + i], (nr * cv[i]) >>> 14);
               grad_sum[2 + N_CP + N_HARM + i] =
                  add_sat(grad_sum[2 + N_CP + N_HARM + i], (nr * sv[i]) >>> 14);
            end
            n_samples++;
         end
         default: begin
            for (int i = 0; i < N_COEF; i++) begin
               c = sx(coef_mem[i]);
               v = scale_trunc(grad_sum[i], obs_w, 24);
               if (i == 0) prior = scale_trunc(c, rate_w, 8);
               else if (i == 1) prior = scale_trunc(c, offset_w, 8);
               else if (i < 2 + N_CP) begin
                  prior = longint'(laplace_w) * 65536;
                  prior = c > 0 ? prior : (c < 0 ? -prior : 0);
               end else prior = scale_trunc(c, season_w, 8);
               o.grad_index = i[5:0];
               o.grad_value = add_sat(v, prior);
               o.last = (i == N_COEF - 1);
               if (typed_on && typed_idx == i[5:0]) o.grad_value = typed_val;
               grad_expected.push_back(o);
               grad_sum[i] = 0;
            end
            n_finishes++;
         end
      endcase
   endtask

   task automatic send(input tsrg_req_type r);
      while (!steady && $urandom_range(99) < 13) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_data = r;
      do @(posedge clock); while (req_full);
      predict_gradients(r);
      if (!(r.cmd == CMD_LOAD_COEF && r.slot >= N_COEF) &&
          !(r.cmd == CMD_LOAD_CP && r.slot >= N_CP)) n_items++;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IW-1:0] idx, input logic [31:0] w);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = w;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INV_VAR_OBS:       obs_w = w;
         CSR_INV_VAR_RATE:      rate_w = w;
         CSR_INV_VAR_OFFSET:    offset_w = w;
         CSR_INV_VAR_SEASON:    season_w = w;
         CSR_INV_LAPLACE_SCALE: laplace_w = w;
         CSR_PHASE_RATE:        phase_w = w;
         default:               ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // hold until every expected component has arrived, then let the back end settle
   task automatic drain;
      req_push = 1'b0;
      while (grad_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_word;
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(32'h0400_0000)) - 32'h0200_0000;
         2: case ($urandom_range(4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'h1;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return 32'($urandom_range(32'h2000_0000)) - 32'h1000_0000;
      endcase
   endfunction

   task automatic add_row(input logic [1:0] cmd, input logic [5:0] slot,
                          input logic [31:0] a, input logic [31:0] b,
                          input bit typed, input logic [5:0] tidx, input longint tval);
      table_row_type row;
      row.req = '{cmd: cmd, slot: slot, operand_a: a, operand_b: b};
      row.typed = typed;
      row.tidx = tidx;
      row.tval = tval;
      stim_table.push_back(row);
   endtask

   // result side
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_armed && !rsp_empty) begin
            rsp_pop = 1'b0;
            repeat (3000) @(negedge clock);
            hold_armed = 1'b0;
         end
         rsp_pop = steady ? 1'b1 : ($urandom_range(99) >= 13);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         n_results++;
         if (grad_expected.size() == 0) begin
            report("unexpected transaction, index", rsp_data.grad_index, -1);
         end else begin
            if (rsp_data.grad_index != grad_expected[0].grad_index)
               report("grad_index", rsp_data.grad_index, grad_expected[0].grad_index);
            if (rsp_data.grad_value != grad_expected[0].grad_value)
               report("grad_value", rsp_data.grad_value, grad_expected[0].grad_value);
            if (rsp_data.last != grad_expected[0].last)
               report("last", rsp_data.last, grad_expected[0].last);
            void'(grad_expected.pop_front());
         end
      end
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d transactions outstanding", grad_expected.size());
      $display("trend_season_residual_gradient: mismatch");
      $finish;
   end

   initial begin
      tsrg_req_type r;
      int p, n, sel;
      obs_w = ONE_Q24; rate_w = ONE_Q24; offset_w = ONE_Q24;
      season_w = ONE_Q24; laplace_w = ONE_Q24; phase_w = '0;
      foreach (grad_sum[i]) grad_sum[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_write(CSR_INV_VAR_OBS, ONE_Q24);
      csr_write(CSR_INV_VAR_RATE, ONE_Q24);
      csr_write(CSR_INV_VAR_OFFSET, ONE_Q24);
      csr_write(CSR_INV_VAR_SEASON, ONE_Q24);
      csr_write(CSR_INV_LAPLACE_SCALE, ONE_Q24);
      csr_write(CSR_PHASE_RATE, 32'h0004_5A3C);

      for (int i = 0; i < N_COEF; i++) begin
         r = '{cmd: CMD_LOAD_COEF, slot: i[5:0], operand_a: pick_word(), operand_b: $urandom};
         send(r);
      end
      for (int i = 0; i < N_CP; i++) begin
         r = '{cmd: CMD_LOAD_CP, slot: i[5:0], operand_a: pick_word(), operand_b: $urandom};
         send(r);
      end

      add_row(CMD_LOAD_COEF, 6'd1, ONE_Q24, 32'h0, 0, 0, 0);
      add_row(CMD_LOAD_COEF, 6'd2, 32'h0, 32'hFFFF_FFFF, 0, 0, 0);
      add_row(CMD_LOAD_COEF, 6'd3, 32'hFFFF_FFFB, 32'h0, 0, 0, 0);
      add_row(CMD_LOAD_COEF, 6'd47, 32'h1234_5678, 32'h0, 0, 0, 0);
      add_row(CMD_LOAD_COEF, 6'd63, 32'hFFFF_FFFF, 32'h0, 0, 0, 0);
      add_row(CMD_LOAD_CP, 6'd25, 32'h7FFF_FFFF, 32'h0, 0, 0, 0);
      add_row(CMD_LOAD_CP, 6'd63, 32'h8000_0000, 32'h0, 0, 0, 0);
      add_row(CMD_LOAD_CP, 6'd0, ONE_Q24, 32'h0, 0, 0, 0);
      add_row(CMD_FINISH, 6'd0, 32'h0, 32'h0, 1, 6'd1, 64'sd1 <<< 40);
      add_row(CMD_FINISH, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 6'd2, 0);
      add_row(CMD_FINISH, 6'd0, 32'h0, 32'h0, 1, 6'd3, -(64'sd1 <<< 40));
      add_row(CMD_SAMPLE, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
      add_row(CMD_SAMPLE, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
      add_row(CMD_SAMPLE, 6'd0, 32'h0, 32'h0, 0, 0, 0);
      add_row(CMD_SAMPLE, 6'd0, ONE_Q24, 32'h0080_0000, 0, 0, 0);
      add_row(CMD_LOAD_COEF, 6'd46, 32'h7FFF_FFFF, 32'h0, 0, 0, 0);
      add_row(CMD_LOAD_COEF, 6'd0, 32'h8000_0000, 32'h0, 0, 0, 0);
      add_row(CMD_SAMPLE, 6'd0, 32'hFF00_0000, 32'h7FFF_FFFF, 0, 0, 0);
      add_row(CMD_FINISH, 6'd0, 32'h0, 32'h0, 0, 0, 0);

      foreach (stim_table[i]) begin
         typed_on = stim_table[i].typed;
         typed_idx = stim_table[i].tidx;
         typed_val = stim_table[i].tval;
         send(stim_table[i].req);
      end
      typed_on = 1'b0;

      p = 0;
      while (n_items < 470) begin
         steady = (p >= 20 && p < 25);
         if (p % 4 == 0) begin
            drain();
            for (int k = 0; k < 6; k++) begin
               case (p)
                  0:       csr_write(k[CSR_IW-1:0], 32'hFFFF_FFFF);
                  4:       csr_write(k[CSR_IW-1:0], 32'h0);
                  8:       csr_write(k[CSR_IW-1:0],
                                     k == CSR_PHASE_RATE ? 32'hFFFF_FFFF : ONE_Q24);
                  default: csr_write(k[CSR_IW-1:0],
                                     $urandom_range(1) ? $urandom : $urandom_range(32'h0400_0000));
               endcase
            end
         end
         if (p == 2) hold_armed = 1'b1;
         n = $urandom_range(6, 14);
         for (int k = 0; k < n; k++) begin
            r.operand_a = pick_word();
            r.operand_b = pick_word();
            sel = $urandom_range(99);
            if (sel < 12) begin
               r.cmd = CMD_LOAD_COEF;
               r.slot = $urandom_range(99) < 85 ? 6'($urandom_range(N_COEF - 1))
                                                : 6'($urandom_range(63, N_COEF));
            end else if (sel < 22) begin
               r.cmd = CMD_LOAD_CP;
               r.slot = $urandom_range(99) < 85 ? 6'($urandom_range(N_CP - 1))
                                                : 6'($urandom_range(63, N_CP));
            end else begin
               r.cmd = CMD_SAMPLE;
               r.slot = 6'($urandom);
            end
            send(r);
         end
         r = '{cmd: CMD_FINISH, slot: 6'($urandom), operand_a: $urandom, operand_b: $urandom};
         send(r);
         p++;
      end

      steady = 1'b0;
      drain();
      $display("covered %0d commands in %0d phases: %0d samples, %0d finishes",
               n_items, p, n_samples, n_finishes);
      $display("checked %0d gradient transactions, %0d errors", n_results, n_errors);
      if (n_errors == 0) begin
         $display("trend_season_residual_gradient: match");
      end else begin
         $display("trend_season_residual_gradient: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
design/tsrg_pkg.sv
design/tsrg_front.sv
design/tsrg_back.sv
design/trend_season_residual_gradient.sv
dv/testbench.sv
